>>> design/egbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egbp_pkg: shared types and constants of the exp-Golomb bit packer
// Command and status codes, queue entry layout and fixed limits.
// ----------------------------------------------------------------------------
package egbp_pkg;

	typedef enum logic [1:0] {
		CMD_RAW    = 2'd0,
		CMD_UE     = 2'd1,
		CMD_SE     = 2'd2,
		CMD_FINISH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ARG   = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_FLUSH  = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	// A data entry appends the low count bits of word, first bit first.
	// Bit positions 32 and above read as zero, which gives the exp-Golomb prefix.
	typedef struct packed {
		kind_t        kind;
		status_t      status;
		logic [31:0]  word;
		logic [5:0]   count;
	} entry_t;

	localparam int MaxRawBits = 32;
	localparam int QueueDepth = 2;

endpackage

>>> design/egbp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egbp_if: channel interfaces of the exp-Golomb bit packer
// Input command words and output byte words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface egbp_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [31:0]        bits_value;
	logic [5:0]         raw_len;
	logic signed [31:0] signed_value;

	modport source (output valid, command, bits_value, raw_len, signed_value, input ready);
	modport sink (input valid, command, bits_value, raw_len, signed_value, output ready);
endinterface

interface egbp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic [1:0] status;
	logic       last;

	modport source (output valid, out_byte, byte_valid, status, last, input ready);
	modport sink (input valid, out_byte, byte_valid, status, last, output ready);
endinterface

>>> design/egbp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egbp_front: command intake and classification
// Checks each command, maps it to a bit field of up to 63 bits and pushes
// one queue entry per command.
// ----------------------------------------------------------------------------
module egbp_front (
	input  logic               clk,
	input  logic               arst_n,
	egbp_in_if.sink            items,
	input  logic               full,
	output logic               push,
	output egbp_pkg::entry_t   entry
);

	logic                      valid_s1;
	egbp_pkg::kind_t           kind_s1;
	egbp_pkg::status_t         status_s1;
	logic [31:0]               word_s1;
	logic [5:0]                count_s1;
	logic                      eg_s1;

	egbp_pkg::kind_t           kind_d;
	egbp_pkg::status_t         status_d;
	logic [31:0]               word_d;
	logic                      eg_d;
	logic [31:0]               neg_sv;
	logic                      accept;
	logic [4:0]                lead;

	assign items.ready = !valid_s1 || !full;
	assign accept      = items.valid && items.ready;
	assign push        = valid_s1 && !full;
	assign neg_sv      = 32'd0 - items.signed_value;

	always_comb begin
		kind_d   = egbp_pkg::KIND_DATA;
		status_d = egbp_pkg::ST_OK;
		word_d   = items.bits_value;
		eg_d     = 1'b0;
		unique case (egbp_pkg::cmd_t'(items.command))
			egbp_pkg::CMD_RAW: begin
				if (items.raw_len > 6'(egbp_pkg::MaxRawBits)) begin
					kind_d   = egbp_pkg::KIND_STATUS;
					status_d = egbp_pkg::ST_ARG;
				end else if (items.raw_len < 6'd32 &&
					(items.bits_value >> items.raw_len[4:0]) != 32'd0) begin
					kind_d   = egbp_pkg::KIND_STATUS;
					status_d = egbp_pkg::ST_ARG;
				end
			end
			egbp_pkg::CMD_UE: begin
				eg_d   = 1'b1;
				word_d = items.bits_value + 32'd1;
				if (items.bits_value == 32'hFFFF_FFFF) begin
					kind_d   = egbp_pkg::KIND_STATUS;
					status_d = egbp_pkg::ST_RANGE;
				end
			end
			egbp_pkg::CMD_SE: begin
				eg_d = 1'b1;
				// Code is the mapped value plus one: 2v for v > 0, 1 - 2v otherwise.
				if (items.signed_value[31] || items.signed_value == 32'sd0) begin
					word_d = {neg_sv[30:0], 1'b1};
				end else begin
					word_d = {items.signed_value[30:0], 1'b0};
				end
				if (items.signed_value == 32'sh8000_0000) begin
					kind_d   = egbp_pkg::KIND_STATUS;
					status_d = egbp_pkg::ST_RANGE;
				end
			end
			egbp_pkg::CMD_FINISH: begin
				kind_d = egbp_pkg::KIND_FLUSH;
			end
			default: begin
				kind_d = egbp_pkg::KIND_FLUSH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind_d;
			status_s1 <= status_d;
			word_s1   <= word_d;
			count_s1  <= items.raw_len;
			eg_s1     <= eg_d;
		end
	end

	// Position of the leading one of the code; the code is never zero here.
	always_comb begin
		lead = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (word_s1[i]) begin
				lead = 5'(i);
			end
		end
	end

	always_comb begin
		entry.kind   = kind_s1;
		entry.status = status_s1;
		entry.word   = word_s1;
		entry.count  = eg_s1 ? {lead, 1'b1} : count_s1;
	end

endmodule

>>> design/egbp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egbp_queue: small entry queue between intake and packing
// Lets the intake run ahead while the packer drains long codes.
// ----------------------------------------------------------------------------
module egbp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  egbp_pkg::entry_t   entry,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output egbp_pkg::entry_t   head
);

	localparam int PtrW = $clog2(egbp_pkg::QueueDepth);
	localparam int CntW = $clog2(egbp_pkg::QueueDepth + 1);

	egbp_pkg::entry_t          mem [egbp_pkg::QueueDepth];
	logic [PtrW-1:0]           wptr_q;
	logic [PtrW-1:0]           rptr_q;
	logic [CntW-1:0]           fill_q;

	assign full       = fill_q == CntW'(egbp_pkg::QueueDepth);
	assign head_valid = fill_q != '0;
	assign head       = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PtrW'(egbp_pkg::QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PtrW'(egbp_pkg::QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= entry;
		end
	end

endmodule

>>> design/egbp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egbp_back: bit accumulator and byte emitter
// Works on the queue head and emits one result word per cycle into an output
// register unless stalled; keeps up to seven pending bits between commands.
// ----------------------------------------------------------------------------
module egbp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  egbp_pkg::entry_t   head,
	output logic               pop,
	egbp_out_if.source         results
);

	logic [6:0]  pend_q;
	logic [2:0]  pcnt_q;
	logic [5:0]  rem_q;
	logic        mid_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_bv_q;
	logic [1:0]  out_status_q;
	logic        out_last_q;

	logic        step;
	logic [5:0]  cur_rem;
	logic [6:0]  total;
	logic [3:0]  k;
	logic [5:0]  sh;
	logic [63:0] wide;
	logic [7:0]  chunk;
	logic [7:0]  pend8;
	logic [7:0]  byte_full;

	logic [6:0]  pend_n;
	logic [2:0]  pcnt_n;
	logic [5:0]  rem_n;
	logic        mid_n;
	logic        done;
	logic [7:0]  res_byte;
	logic        res_bv;
	logic [1:0]  res_status;

	function automatic logic [6:0] low_mask(input logic [2:0] n);
		low_mask = ~(7'h7F << n);
	endfunction

	assign step    = head_valid && (!out_valid_q || results.ready);
	assign pop     = step && done;
	assign cur_rem = mid_q ? rem_q : head.count;
	assign total   = {4'd0, pcnt_q} + {1'b0, cur_rem};
	assign k       = 4'd8 - {1'b0, pcnt_q};
	assign sh      = cur_rem - {2'd0, k};
	assign wide    = {32'd0, head.word} >> sh;
	assign chunk   = wide[7:0] & (8'hFF >> pcnt_q);
	assign pend8   = {1'b0, pend_q};
	assign byte_full = (pend8 << k) | chunk;

	always_comb begin
		pend_n     = pend_q;
		pcnt_n     = pcnt_q;
		rem_n      = rem_q;
		mid_n      = 1'b0;
		done       = 1'b1;
		res_byte   = 8'd0;
		res_bv     = 1'b0;
		res_status = egbp_pkg::ST_OK;
		unique case (head.kind)
			egbp_pkg::KIND_DATA: begin
				if (total >= 7'd8) begin
					res_byte = byte_full;
					res_bv   = 1'b1;
					if (sh < 6'd8) begin
						// Final byte of this word: the tail goes to the pending bits.
						pend_n = head.word[6:0] & low_mask(sh[2:0]);
						pcnt_n = sh[2:0];
					end else begin
						pend_n = 7'd0;
						pcnt_n = 3'd0;
						rem_n  = sh;
						mid_n  = 1'b1;
						done   = 1'b0;
					end
				end else begin
					pend_n = (pend_q << cur_rem[2:0]) | (head.word[6:0] & low_mask(cur_rem[2:0]));
					pcnt_n = total[2:0];
				end
			end
			egbp_pkg::KIND_FLUSH: begin
				if (pcnt_q != 3'd0) begin
					res_byte = pend8 << k;
					res_bv   = 1'b1;
					pend_n   = 7'd0;
					pcnt_n   = 3'd0;
				end
			end
			egbp_pkg::KIND_STATUS: begin
				res_status = head.status;
			end
			default: begin
				res_status = head.status;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 7'd0;
			pcnt_q      <= 3'd0;
			rem_q       <= 6'd0;
			mid_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (step) begin
			pend_q      <= pend_n;
			pcnt_q      <= pcnt_n;
			rem_q       <= rem_n;
			mid_q       <= mid_n;
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q   <= res_byte;
			out_bv_q     <= res_bv;
			out_status_q <= res_status;
			out_last_q   <= done;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.out_byte   = out_byte_q;
	assign results.byte_valid = out_bv_q;
	assign results.status     = out_status_q;
	assign results.last       = out_last_q;

endmodule

>>> design/exp_golomb_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_golomb_bit_packer: MSB-first bit packer with exp-Golomb coding
// Raw, unsigned and signed exp-Golomb appends and a zero-padded flush; every
// completed byte leaves as one output word.
// ----------------------------------------------------------------------------
// Channel   Dir  Word                                             Handshake
// items     in   command, bits_value, raw_len, signed_value       valid/ready
// results   out  out_byte, byte_valid, status, last               valid/ready
//
// A command passes the intake register, a two-entry queue and the output
// register before its first result word is valid and can be taken.
// The packer emits one result word per cycle while the output is not stalled;
// a command has one to eight result words.
// Reset clears the pending bits, the queue and all valid flags.
// A stalled output holds the packer; the queue lets intake run two commands ahead.
// ----------------------------------------------------------------------------
module exp_golomb_bit_packer (
	input  logic        clk,
	input  logic        arst_n,
	egbp_in_if.sink     items,
	egbp_out_if.source  results
);

	logic               push;
	logic               full;
	logic               pop;
	logic               head_valid;
	egbp_pkg::entry_t   entry;
	egbp_pkg::entry_t   head;

	egbp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.full   (full),
		.push   (push),
		.entry  (entry)
	);

	egbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.entry      (entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	egbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.results    (results)
	);

endmodule
